// ----- hw/rtl/vmd_pkg.sv -----
package vmd_pkg;

	// Field and register widths
	localparam int PIX_W     = 8;
	localparam int CFG_W     = 12;
	localparam int ROW_W     = 12;
	localparam int CFG_IDX_W = 1;

	// Default line store depth in bytes
	localparam int MAX_ROW_BYTES_DEF = 2048;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 1'd1;

	// Register reset values and lower limits
	localparam logic [CFG_W-1:0] ROW_BYTES_RESET  = 12'd1440;
	localparam logic [CFG_W-1:0] FRAME_ROWS_RESET = 12'd576;
	localparam logic [CFG_W-1:0] ROW_BYTES_MIN    = 12'd2;
	localparam logic [CFG_W-1:0] FRAME_ROWS_MIN   = 12'd3;

	// Results caused by one input byte: the byte one row up, then the
	// frame's closing byte on the last input of a frame
	typedef struct packed {
		logic             has_main;
		logic [PIX_W-1:0] main_byte;
		logic             has_last;
		logic [PIX_W-1:0] last_byte;
	} vmd_pair_t;

	// Median of three unsigned bytes
	function automatic logic [PIX_W-1:0] median3(
		input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b,
		input logic [PIX_W-1:0] c
	);
		logic [PIX_W-1:0] lo;
		logic [PIX_W-1:0] hi;
		logic [PIX_W-1:0] m;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c <= lo) m = lo;
		else if (c >= hi) m = hi;
		else m = c;
		return m;
	endfunction

endpackage

// ----- hw/rtl/vmd_pixel_if.sv -----
interface vmd_pixel_if;
	logic                      valid;
	logic                      ready;
	logic [vmd_pkg::PIX_W-1:0] pixel_byte;

	modport source (output valid, output pixel_byte, input ready);
	modport sink   (input valid, input pixel_byte, output ready);
endinterface

// ----- hw/rtl/vmd_result_if.sv -----
interface vmd_result_if;
	logic                      valid;
	logic                      ready;
	logic [vmd_pkg::PIX_W-1:0] out_byte;
	logic                      frame_end;
	logic                      run_last;

	modport source (output valid, output out_byte, output frame_end, output run_last,
		input ready);
	modport sink   (input valid, input out_byte, input frame_end, input run_last,
		output ready);
endinterface

// ----- hw/rtl/vmd_ram.sv -----
module vmd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	// Registered read port, holds its data until the next read
	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/vmd_out_stage.sv -----
module vmd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_valid,
	input  vmd_pkg::vmd_pair_t  load_pair,
	output logic                load_ready,
	vmd_result_if.source        results
);

	logic               valid_q;
	logic               first_done_q;
	vmd_pkg::vmd_pair_t pair_q;

	logic cur_is_main;
	logic fire;
	logic finishing;
	logic load;
	logic load_any;

	// Pick the pending result: main byte first, then the closing byte
	always_comb begin
		cur_is_main = pair_q.has_main && !first_done_q;
		fire        = valid_q && results.ready;
		finishing   = fire && (!cur_is_main || !pair_q.has_last);
		load_ready  = !valid_q || finishing;
		load        = load_valid && load_ready;
		load_any    = load_pair.has_main || load_pair.has_last;
	end

	assign results.valid     = valid_q;
	assign results.out_byte  = cur_is_main ? pair_q.main_byte : pair_q.last_byte;
	assign results.frame_end = !cur_is_main;
	assign results.run_last  = !cur_is_main || !pair_q.has_last;

	// Hold the pair until every result in it has been transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			first_done_q <= 1'b0;
		end else if (load) begin
			valid_q      <= load_any;
			first_done_q <= 1'b0;
		end else if (finishing) begin
			valid_q      <= 1'b0;
		end else if (fire) begin
			first_done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) pair_q <= load_pair;
	end

endmodule

// ----- hw/rtl/vertical_median_deinterlace_core.sv -----
// Vertical median deinterlacer for a raster stream of packed YUV bytes.
//
// Channels: "pixels" takes one frame byte per transfer in raster order;
// "results" gives deinterlaced bytes in raster order, one row behind input.
// Odd rows with a row below are replaced by the median of the bytes above,
// at and below each position; even rows and a final odd row pass as is.
// The last input byte of a frame gives two results: the byte one row up,
// then itself with frame_end set. Row 0 of a frame gives no results.
//
// Throughput: one byte per cycle while "results" is ready, except that the
// frame's closing byte can hold "pixels" while its second result goes out. Each
// byte takes one read and one write of the line store (one dual-port RAM
// holding the two previous rows side by side); reads and writes of
// consecutive bytes hit different columns, so no forwarding is needed. A
// result is registered in stage 1 and then in the output stage before it is
// presented; the frame's closing byte follows the byte one row up.
// Reset clears the counters and loads row_bytes = 1440, frame_rows = 576;
// the line store is not cleared. When the receiver stalls, the result is held
// and the stall backs up into "pixels" after one buffered byte. The user must
// write registers via cfg_we/cfg_index/cfg_data only while idle; not enforced.
module vertical_median_deinterlace_core #(
	parameter int MAX_ROW_BYTES = vmd_pkg::MAX_ROW_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [vmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vmd_pkg::CFG_W-1:0]     cfg_data,
	vmd_pixel_if.sink                     pixels,
	vmd_result_if.source                  results
);

	localparam int CNTW = $clog2(MAX_ROW_BYTES);
	localparam int CMPW = (CNTW + 1 > vmd_pkg::CFG_W + 1) ? CNTW + 1 : vmd_pkg::CFG_W + 1;
	localparam int PW   = vmd_pkg::PIX_W;
	localparam int RW   = vmd_pkg::ROW_W;

	// Configuration registers
	logic [vmd_pkg::CFG_W-1:0] row_bytes_q;
	logic [vmd_pkg::CFG_W-1:0] frame_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q  <= vmd_pkg::ROW_BYTES_RESET;
			frame_rows_q <= vmd_pkg::FRAME_ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				vmd_pkg::CFG_ROW_BYTES:  row_bytes_q  <= cfg_data;
				vmd_pkg::CFG_FRAME_ROWS: frame_rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the registers to their working ranges
	logic [CMPW-1:0]           rb_ext;
	logic [CMPW-1:0]           rb_eff;
	logic [vmd_pkg::CFG_W-1:0] fr_eff;

	always_comb begin
		rb_ext = CMPW'(row_bytes_q);
		if (rb_ext < CMPW'(vmd_pkg::ROW_BYTES_MIN)) rb_eff = CMPW'(vmd_pkg::ROW_BYTES_MIN);
		else if (rb_ext > CMPW'(MAX_ROW_BYTES))     rb_eff = CMPW'(MAX_ROW_BYTES);
		else                                        rb_eff = rb_ext;
		fr_eff = (frame_rows_q < vmd_pkg::FRAME_ROWS_MIN) ? vmd_pkg::FRAME_ROWS_MIN
			: frame_rows_q;
	end

	// Position counters
	logic [CNTW-1:0] col_q;
	logic [RW-1:0]   row_q;
	logic            row_end;
	logic            frame_last;
	logic            accept;

	assign row_end    = (CMPW'(col_q) + CMPW'(1)) >= rb_eff;
	assign frame_last = row_end && ({1'b0, row_q} + (RW+1)'(1) >= {1'b0, fr_eff});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_last ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CNTW'(1);
			end
		end
	end

	// Stage 1: line store read data arrives, compute the result pair
	logic            valid_s1;
	logic [PW-1:0]   px_s1;
	logic [CNTW-1:0] col_s1;
	logic            has_main_s1;
	logic            use_med_s1;
	logic            frame_last_s1;

	logic [2*PW-1:0]    rd_data;
	logic [PW-1:0]      older_rd;
	logic [PW-1:0]      prev_rd;
	logic               load_ready;
	logic               s1_adv;
	vmd_pkg::vmd_pair_t pair;

	assign older_rd = rd_data[2*PW-1:PW];
	assign prev_rd  = rd_data[PW-1:0];

	assign s1_adv       = valid_s1 && load_ready;
	assign pixels.ready = !valid_s1 || load_ready;
	assign accept       = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1         <= pixels.pixel_byte;
			col_s1        <= col_q;
			has_main_s1   <= (row_q != '0);
			use_med_s1    <= !row_q[0];
			frame_last_s1 <= frame_last;
		end
	end

	always_comb begin
		pair.has_main  = has_main_s1;
		pair.main_byte = use_med_s1 ? vmd_pkg::median3(older_rd, prev_rd, px_s1) : prev_rd;
		pair.has_last  = frame_last_s1;
		pair.last_byte = px_s1;
	end

	// Line store: {row two above, row above}, shifted down as a byte leaves stage 1
	vmd_ram #(
		.WIDTH(2 * PW),
		.DEPTH(MAX_ROW_BYTES)
	) u_line_ram (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(col_s1),
		.wdata({prev_rd, px_s1}),
		.re   (accept),
		.raddr(col_q),
		.rdata(rd_data)
	);

	vmd_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_valid(s1_adv),
		.load_pair (pair),
		.load_ready(load_ready),
		.results   (results)
	);

	// The line store has no forwarding: a write never shares a column with a read
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && accept) |-> (col_s1 != col_q))
		else $error("line store read and write hit the same column");

	// Consecutive bytes always move to another column
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (col_q != $past(col_q)))
		else $error("column counter did not move after a transfer");

	// A stalled stage 1 keeps its line store data
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> $stable(rd_data))
		else $error("line store data changed under a stalled byte");

	// The frame's closing byte is always the last result of its input
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.frame_end) |-> results.run_last)
		else $error("frame_end result not marked as last");

endmodule
